>>> sv/twdg_pkg.sv
package twdg_pkg;

   // Default sizing
   localparam int PRELOAD_BITS_DEFAULT     = 20;
   localparam int SLOW_DIVIDE_LOG2_DEFAULT = 15;
   localparam int FAST_DIVIDE_LOG2_DEFAULT = 5;

   // Bus field widths
   localparam int DATA_BITS = 20;
   localparam int WIDE_BITS = 32;

   // Opcodes
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_REG_WRITE  = 3'd1;
   localparam logic [2:0] OP_REG_READ   = 3'd2;
   localparam logic [2:0] OP_LOCK_WRITE = 3'd3;
   localparam logic [2:0] OP_LOCK_READ  = 3'd4;

   // Register offsets
   localparam logic [3:0] OFS_PRELOAD1 = 4'd0;
   localparam logic [3:0] OFS_PRELOAD2 = 4'd4;
   localparam logic [3:0] OFS_STATUS   = 4'd8;
   localparam logic [3:0] OFS_RELOAD   = 4'd12;

   // Configuration register indexes
   localparam logic [1:0] CSR_REBOOT_DISABLE = 2'd0;
   localparam logic [1:0] CSR_FAST_CLOCK     = 2'd1;
   localparam logic [1:0] CSR_INT_KIND       = 2'd2;

   // Interrupt kinds
   localparam logic [1:0] INT_KIND_IRQ  = 2'd0;
   localparam logic [1:0] INT_KIND_SMI  = 2'd2;
   localparam logic [1:0] INT_KIND_NONE = 2'd3;

   // Unlock keys and bit positions
   localparam logic [DATA_BITS-1:0] KEY_ONE = 20'h00080;
   localparam logic [DATA_BITS-1:0] KEY_TWO = 20'h00086;
   localparam int RELOAD_TIMEOUT_BIT = 9;
   localparam int RELOAD_RESTART_BIT = 8;
   localparam int LOCK_ENABLE_BIT    = 1;
   localparam int LOCK_LOCK_BIT      = 0;
   localparam int STATUS_CLEAR_BIT   = 0;

   typedef struct packed {
      logic [2:0]           opcode;
      logic [3:0]           offset;
      logic [DATA_BITS-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] read_value;
      logic                 irq_request;
      logic                 smi_request;
      logic                 reboot_request;
      logic                 timeout_seen;
      logic                 running;
   } rsp_type;

endpackage

>>> sv/two_stage_watchdog_device_unit.sv
// The response to an accepted request is held in the result register from the next cycle.
// Throughput: one request per cycle; a new request is taken whenever the result
// register is empty or its response is taken in the same cycle.
// Reset: synchronous, active high; clears all timer, unlock and lock state, sets
// the interrupt kind to none, and empties the result register.
module two_stage_watchdog_device_unit #(
   parameter int PRELOAD_BITS     = twdg_pkg::PRELOAD_BITS_DEFAULT,
   parameter int SLOW_DIVIDE_LOG2 = twdg_pkg::SLOW_DIVIDE_LOG2_DEFAULT,
   parameter int FAST_DIVIDE_LOG2 = twdg_pkg::FAST_DIVIDE_LOG2_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  twdg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output twdg_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [1:0]        csr_data
);

   localparam int PRESCALE_BITS =
      (SLOW_DIVIDE_LOG2 > FAST_DIVIDE_LOG2) ? SLOW_DIVIDE_LOG2 :
      ((FAST_DIVIDE_LOG2 > 0) ? FAST_DIVIDE_LOG2 : 1);
   localparam logic [PRESCALE_BITS-1:0] SLOW_MASK =
      PRESCALE_BITS'((64'd1 << SLOW_DIVIDE_LOG2) - 64'd1);
   localparam logic [PRESCALE_BITS-1:0] FAST_MASK =
      PRESCALE_BITS'((64'd1 << FAST_DIVIDE_LOG2) - 64'd1);

   typedef enum logic [1:0] {
      LOCKED   = 2'd0,
      KEY_SEEN = 2'd1,
      OPENED   = 2'd2
   } unlock_type;

   // Configuration
   logic       reboot_disable_ff;
   logic       fast_clock_ff;
   logic [1:0] int_kind_ff;

   // Timer state
   logic [PRELOAD_BITS-1:0]  first_preload_ff,  first_preload_in;
   logic [PRELOAD_BITS-1:0]  second_preload_ff, second_preload_in;
   logic [PRELOAD_BITS-1:0]  down_counter_ff,   down_counter_in;
   logic [PRESCALE_BITS-1:0] prescale_ff,       prescale_in;
   logic                     second_stage_ff,   second_stage_in;
   unlock_type               unlock_ff,         unlock_in;
   logic                     enabled_ff,        enabled_in;
   logic                     lock_frozen_ff,    lock_frozen_in;
   logic                     timeout_ff,        timeout_in;
   logic                     status_ff,         status_in;

   // Result register
   logic              rsp_valid_ff;
   twdg_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                                 req_fire;
   logic [twdg_pkg::DATA_BITS-1:0]       wv;
   logic [twdg_pkg::WIDE_BITS-1:0]       wv_wide;
   logic [twdg_pkg::WIDE_BITS-1:0]       pl1_wide;
   logic [twdg_pkg::WIDE_BITS-1:0]       pl2_wide;
   logic [PRESCALE_BITS-1:0]             prescale_step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign wv       = req_data.write_value;
   assign wv_wide  = twdg_pkg::WIDE_BITS'(wv);
   assign pl1_wide = twdg_pkg::WIDE_BITS'(first_preload_ff);
   assign pl2_wide = twdg_pkg::WIDE_BITS'(second_preload_ff);
   assign prescale_step = (prescale_ff + PRESCALE_BITS'(1)) &
                          (fast_clock_ff ? FAST_MASK : SLOW_MASK);

   // Work out the next state and the response of the current request
   always_comb begin
      first_preload_in  = first_preload_ff;
      second_preload_in = second_preload_ff;
      down_counter_in   = down_counter_ff;
      prescale_in       = prescale_ff;
      second_stage_in   = second_stage_ff;
      unlock_in         = unlock_ff;
      enabled_in        = enabled_ff;
      lock_frozen_in    = lock_frozen_ff;
      timeout_in        = timeout_ff;
      status_in         = status_ff;
      rsp_data_in       = '0;

      unique case (req_data.opcode)
         twdg_pkg::OP_TICK: begin
            if (enabled_ff) begin
               prescale_in = prescale_step;
               if (prescale_step == '0) begin
                  if (down_counter_ff != '0) begin
                     down_counter_in = down_counter_ff - PRELOAD_BITS'(1);
                  end else if (!second_stage_ff) begin
                     // Stage one expiry: raise status, signal, load stage two
                     status_in = 1'b1;
                     rsp_data_in.irq_request = (int_kind_ff == twdg_pkg::INT_KIND_IRQ);
                     rsp_data_in.smi_request = (int_kind_ff == twdg_pkg::INT_KIND_SMI);
                     second_stage_in = 1'b1;
                     down_counter_in = second_preload_ff;
                  end else begin
                     // Stage two expiry: flag timeout, request reboot unless disabled, restart stage one
                     timeout_in = 1'b1;
                     rsp_data_in.reboot_request = !reboot_disable_ff;
                     second_stage_in = 1'b0;
                     down_counter_in = first_preload_ff;
                  end
               end
            end
         end
         twdg_pkg::OP_REG_WRITE: begin
            if (req_data.offset == twdg_pkg::OFS_STATUS) begin
               if (wv[twdg_pkg::STATUS_CLEAR_BIT]) status_in = 1'b0;
            end else if (req_data.offset == twdg_pkg::OFS_PRELOAD1 ||
                         req_data.offset == twdg_pkg::OFS_PRELOAD2 ||
                         req_data.offset == twdg_pkg::OFS_RELOAD) begin
               if (unlock_ff == OPENED) begin
                  // Perform the one unlocked write, then lock again
                  if (req_data.offset == twdg_pkg::OFS_PRELOAD1) begin
                     first_preload_in = wv_wide[PRELOAD_BITS-1:0];
                  end else if (req_data.offset == twdg_pkg::OFS_PRELOAD2) begin
                     second_preload_in = wv_wide[PRELOAD_BITS-1:0];
                  end else begin
                     if (wv[twdg_pkg::RELOAD_RESTART_BIT]) begin
                        down_counter_in = first_preload_ff;
                        second_stage_in = 1'b0;
                        prescale_in     = '0;
                     end
                     if (wv[twdg_pkg::RELOAD_TIMEOUT_BIT]) timeout_in = 1'b0;
                  end
                  unlock_in = LOCKED;
               end else if (req_data.offset == twdg_pkg::OFS_RELOAD) begin
                  // Advance the key sequence
                  if (wv == twdg_pkg::KEY_ONE) begin
                     unlock_in = KEY_SEEN;
                  end else if (unlock_ff == KEY_SEEN && wv == twdg_pkg::KEY_TWO) begin
                     unlock_in = OPENED;
                  end else begin
                     unlock_in = LOCKED;
                  end
               end else begin
                  unlock_in = LOCKED;
               end
            end
         end
         twdg_pkg::OP_REG_READ: begin
            if (req_data.offset == twdg_pkg::OFS_PRELOAD1) begin
               rsp_data_in.read_value = pl1_wide[twdg_pkg::DATA_BITS-1:0];
            end else if (req_data.offset == twdg_pkg::OFS_PRELOAD2) begin
               rsp_data_in.read_value = pl2_wide[twdg_pkg::DATA_BITS-1:0];
            end else if (req_data.offset == twdg_pkg::OFS_STATUS) begin
               rsp_data_in.read_value = twdg_pkg::DATA_BITS'(status_ff);
            end else if (req_data.offset == twdg_pkg::OFS_RELOAD) begin
               rsp_data_in.read_value[twdg_pkg::RELOAD_TIMEOUT_BIT] = timeout_ff;
            end
         end
         twdg_pkg::OP_LOCK_WRITE: begin
            if (!lock_frozen_ff) begin
               enabled_in     = wv[twdg_pkg::LOCK_ENABLE_BIT];
               lock_frozen_in = wv[twdg_pkg::LOCK_LOCK_BIT];
            end
         end
         twdg_pkg::OP_LOCK_READ: begin
            rsp_data_in.read_value[twdg_pkg::LOCK_LOCK_BIT]   = lock_frozen_ff;
            rsp_data_in.read_value[twdg_pkg::LOCK_ENABLE_BIT] = enabled_ff;
         end
         default: begin
            // Unused opcodes do nothing
         end
      endcase

      rsp_data_in.timeout_seen = timeout_in;
      rsp_data_in.running      = enabled_in;
   end

   // Hold state, configuration and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         reboot_disable_ff <= 1'b0;
         fast_clock_ff     <= 1'b0;
         int_kind_ff       <= twdg_pkg::INT_KIND_NONE;
         first_preload_ff  <= '0;
         second_preload_ff <= '0;
         down_counter_ff   <= '0;
         prescale_ff       <= '0;
         second_stage_ff   <= 1'b0;
         unlock_ff         <= LOCKED;
         enabled_ff        <= 1'b0;
         lock_frozen_ff    <= 1'b0;
         timeout_ff        <= 1'b0;
         status_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               twdg_pkg::CSR_REBOOT_DISABLE: reboot_disable_ff <= csr_data[0];
               twdg_pkg::CSR_FAST_CLOCK:     fast_clock_ff     <= csr_data[0];
               twdg_pkg::CSR_INT_KIND:       int_kind_ff       <= csr_data;
               default: begin
                  // Drop writes beyond the register list
               end
            endcase
         end
         if (req_fire) begin
            first_preload_ff  <= first_preload_in;
            second_preload_ff <= second_preload_in;
            down_counter_ff   <= down_counter_in;
            prescale_ff       <= prescale_in;
            second_stage_ff   <= second_stage_in;
            unlock_ff         <= unlock_in;
            enabled_ff        <= enabled_in;
            lock_frozen_ff    <= lock_frozen_in;
            timeout_ff        <= timeout_in;
            status_ff         <= status_in;
            rsp_valid_ff      <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff      <= 1'b0;
         end
      end
   end

   // Load the response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Once set, the lock stays set until reset
   assert property (@(posedge clock) disable iff (reset)
      lock_frozen_ff |=> lock_frozen_ff)
      else $error("lock bit cleared without reset");

   // A waiting response reports the current flag levels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.running == enabled_ff &&
                        rsp_data_ff.timeout_seen == timeout_ff))
      else $error("response levels disagree with state");

   // A reboot pulse always comes with the timeout flag set
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.reboot_request) |-> rsp_data_ff.timeout_seen)
      else $error("reboot without timeout flag");

   // Stage one and stage two pulses never share a response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({rsp_data_ff.irq_request, rsp_data_ff.smi_request,
                                   rsp_data_ff.reboot_request}) <= 1)
      else $error("more than one expiry pulse in one response");

   // A step into stage two comes only from a tick
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !second_stage_ff && second_stage_in) |->
         (req_data.opcode == twdg_pkg::OP_TICK))
      else $error("stage two entered without a tick");

endmodule
